@@ design/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants and register codes for the ray against segment
// intersection pipeline and its checker.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // default geometry formats
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // register formats
  localparam int unsigned COS_WIDTH = 17;
  localparam int unsigned COS_FRAC  = 16;
  localparam int unsigned TOL_WIDTH = 16;

  localparam logic [COS_WIDTH-1:0] MAX_COS_RST = COS_WIDTH'(58982);
  localparam logic [TOL_WIDTH-1:0] END_TOL_RST = TOL_WIDTH'(1);

  localparam logic [2*COS_WIDTH-1:0] MAX_COS_SQ_RST =
    (2*COS_WIDTH)'(MAX_COS_RST) * (2*COS_WIDTH)'(MAX_COS_RST);
  localparam logic [2*TOL_WIDTH-1:0] END_TOL_SQ_RST =
    (2*TOL_WIDTH)'(END_TOL_RST) * (2*TOL_WIDTH)'(END_TOL_RST);

  // apb port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_MAX_COS = 1'b0,
    REG_END_TOL = 1'b1
  } rsi_reg_e;

endpackage

@@ design/ray_segment_intersection.sv @@
// ----------------------------------------------------------------------------
// ray_segment_intersection
// Pipelined 2D ray against line segment test in signed fixed point, one
// test per cycle while the input is not held off, with an APB register
// port for the cosine limit and the endpoint tolerance.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                    contents
// s_axis    in         tvalid/tready                origin, direction, window, segment
// m_axis    out        tvalid/tready                tuser = hit, tdata = hit_t
// apb       in/out     psel/penable/pready          max_cos_abs @0x0, endpoint_tolerance @0x4
//
// One item enters per cycle while the skid register is empty. The
// restoring divider resolves one quotient bit per stage, COORD_WIDTH
// stages in all.
// Reset is asynchronous and clears only valid bits and the registers.
// A stalled output parks one more result in a skid register; the input is
// held off only while that skid register is full. Nothing is dropped.
//
module ray_segment_intersection
  import rsi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  localparam int unsigned DW_  = FRAC_BITS + 2,
  localparam int unsigned GW_  = 8*COORD_WIDTH + 2*DW_,
  localparam int unsigned ITW_ = ((GW_ + 7) / 8) * 8,
  localparam int unsigned OTW_ = ((COORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // origin x, origin y, dir x, dir y, t_low, t_high, a x, a y, b x, b y
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ITW_-1:0]   s_axis_tdata,
  // hit_t
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OTW_-1:0]   m_axis_tdata,
  // hit
  output logic              m_axis_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned FB   = FRAC_BITS;
  localparam int unsigned DW   = DW_;
  localparam int unsigned GW   = GW_;
  localparam int unsigned WW   = CW + 1;
  localparam int unsigned PDW  = DW + WW;
  localparam int unsigned DENW = PDW + 1;
  localparam int unsigned SQW  = 2*WW;
  localparam int unsigned NUMW = 2*WW + 1;
  localparam int unsigned DMW  = DENW;
  localparam int unsigned NW   = NUMW + FB;
  localparam int unsigned NHW  = NW - CW;
  localparam int unsigned OVW  = (NHW > DMW) ? NHW : DMW;
  // cosine test widths
  localparam int unsigned M2W  = 2*COS_WIDTH;
  localparam int unsigned DL   = DENW / 2;
  localparam int unsigned DH   = DENW - DL;
  localparam int unsigned D2W  = 2*DENW;
  localparam int unsigned WL   = SQW / 2;
  localparam int unsigned WH   = SQW - WL;
  localparam int unsigned LW   = SQW + M2W;
  localparam int unsigned SH_L = (FB >= COS_FRAC) ? 2*(FB - COS_FRAC) : 0;
  localparam int unsigned SH_D = (FB >= COS_FRAC) ? 0 : 2*(COS_FRAC - FB);
  localparam int unsigned CMPW = ((D2W + SH_D) > (LW + SH_L)) ? D2W + SH_D : LW + SH_L;
  // hit point widths
  localparam int unsigned MW   = DW + CW;
  localparam int unsigned SW   = MW - FB;
  localparam int unsigned HW   = SW + 2;
  localparam int unsigned EW   = HW + 1;
  localparam int unsigned BL   = EW / 2;
  localparam int unsigned PHW  = EW + (EW - BL);
  localparam int unsigned PLW  = EW + BL + 1;
  localparam int unsigned BTW  = 2*EW + 2;
  localparam int unsigned TSW  = 2*TOL_WIDTH;
  // field offsets inside the item
  localparam int unsigned OFF_OX = 0;
  localparam int unsigned OFF_OY = CW;
  localparam int unsigned OFF_VX = 2*CW;
  localparam int unsigned OFF_VY = 2*CW + DW;
  localparam int unsigned OFF_TL = 2*CW + 2*DW;
  localparam int unsigned OFF_TH = OFF_TL + CW;
  localparam int unsigned OFF_AX = OFF_TL + 2*CW;
  localparam int unsigned OFF_AY = OFF_TL + 3*CW;
  localparam int unsigned OFF_BX = OFF_TL + 4*CW;
  localparam int unsigned OFF_BY = OFF_TL + 5*CW;
  // pipeline stages ahead of the output register
  localparam int unsigned NST  = CW + 16;

  localparam logic [CW:0]   Q_HALF  = (CW+1)'(1) << (CW - 1);
  localparam logic [MW-1:0] RND_HLF = MW'(1) << (FB - 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [COS_WIDTH-1:0] mca_q;
  logic [TOL_WIDTH-1:0] tol_q;
  logic [M2W-1:0]       mca_sq_q;
  logic [TSW-1:0]       tol_sq_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mca_q    <= MAX_COS_RST;
      tol_q    <= END_TOL_RST;
      mca_sq_q <= MAX_COS_SQ_RST;
      tol_sq_q <= END_TOL_SQ_RST;
    end else begin
      if (cfg_wr) begin
        unique case (rsi_reg_e'(paddr[2]))
          REG_MAX_COS: mca_q <= pwdata[COS_WIDTH-1:0];
          REG_END_TOL: tol_q <= pwdata[TOL_WIDTH-1:0];
          default: ;
        endcase
      end
      mca_sq_q <= M2W'(mca_q) * M2W'(mca_q);
      tol_sq_q <= TSW'(tol_q) * TSW'(tol_q);
    end
  end

  // register read
  always_comb begin
    unique case (rsi_reg_e'(paddr[2]))
      REG_MAX_COS: prdata = APB_DW'(mca_q);
      REG_END_TOL: prdata = APB_DW'(tol_q);
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic           pipe_en;
  logic [NST-1:0] vld_q;
  logic           skid_vld_q, out_vld_q;

  assign pipe_en       = ~skid_vld_q;
  assign s_axis_tready = pipe_en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // s1: segment direction and origin offset
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] in_ox, in_oy, in_ax, in_ay, in_bx, in_by;
  logic [GW-1:0]        s1_geo_q;
  logic signed [WW-1:0] s1_wx_q, s1_wy_q, s1_px_q, s1_py_q;

  assign in_ox = $signed(s_axis_tdata[OFF_OX +: CW]);
  assign in_oy = $signed(s_axis_tdata[OFF_OY +: CW]);
  assign in_ax = $signed(s_axis_tdata[OFF_AX +: CW]);
  assign in_ay = $signed(s_axis_tdata[OFF_AY +: CW]);
  assign in_bx = $signed(s_axis_tdata[OFF_BX +: CW]);
  assign in_by = $signed(s_axis_tdata[OFF_BY +: CW]);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_geo_q <= s_axis_tdata[GW-1:0];
      s1_wx_q  <= WW'(in_bx) - WW'(in_ax);
      s1_wy_q  <= WW'(in_by) - WW'(in_ay);
      s1_px_q  <= WW'(in_ox) - WW'(in_ax);
      s1_py_q  <= WW'(in_oy) - WW'(in_ay);
    end
  end

  // --------------------------------------------------------------------------
  // s2: products
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]  s1_vx, s1_vy;
  logic [GW-1:0]         s2_geo_q;
  logic signed [PDW-1:0] s2_dn1_q, s2_dn2_q, s2_dt1_q, s2_dt2_q;
  logic signed [SQW-1:0] s2_sqx_q, s2_sqy_q, s2_n1_q, s2_n2_q;

  assign s1_vx = $signed(s1_geo_q[OFF_VX +: DW]);
  assign s1_vy = $signed(s1_geo_q[OFF_VY +: DW]);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_geo_q <= s1_geo_q;
      s2_dn1_q <= PDW'(s1_vx) * PDW'(s1_wy_q);
      s2_dn2_q <= PDW'(s1_vy) * PDW'(s1_wx_q);
      s2_dt1_q <= PDW'(s1_vx) * PDW'(s1_wx_q);
      s2_dt2_q <= PDW'(s1_vy) * PDW'(s1_wy_q);
      s2_sqx_q <= SQW'(s1_wx_q) * SQW'(s1_wx_q);
      s2_sqy_q <= SQW'(s1_wy_q) * SQW'(s1_wy_q);
      s2_n1_q  <= SQW'(s1_wx_q) * SQW'(s1_py_q);
      s2_n2_q  <= SQW'(s1_wy_q) * SQW'(s1_px_q);
    end
  end

  // --------------------------------------------------------------------------
  // s3: cross and dot sums
  // --------------------------------------------------------------------------
  logic [GW-1:0]          s3_geo_q;
  logic signed [DENW-1:0] s3_den_q, s3_dot_q;
  logic [SQW-1:0]         s3_wsq_q;
  logic signed [NUMW-1:0] s3_num_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_geo_q <= s2_geo_q;
      s3_den_q <= DENW'(s2_dn1_q) - DENW'(s2_dn2_q);
      s3_dot_q <= DENW'(s2_dt1_q) + DENW'(s2_dt2_q);
      s3_wsq_q <= $unsigned(s2_sqx_q) + $unsigned(s2_sqy_q);
      s3_num_q <= NUMW'(s2_n1_q) - NUMW'(s2_n2_q);
    end
  end

  // --------------------------------------------------------------------------
  // s4: magnitudes and signs
  // --------------------------------------------------------------------------
  logic [GW-1:0]   s4_geo_q;
  logic [DMW-1:0]  s4_dm_q, s4_dotm_q;
  logic [NUMW-1:0] s4_nm_q;
  logic [SQW-1:0]  s4_wsq_q;
  logic            s4_dz_q, s4_tneg_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s4_geo_q  <= s3_geo_q;
      s4_dm_q   <= s3_den_q[DENW-1] ? $unsigned(-s3_den_q) : $unsigned(s3_den_q);
      s4_dotm_q <= s3_dot_q[DENW-1] ? $unsigned(-s3_dot_q) : $unsigned(s3_dot_q);
      s4_nm_q   <= s3_num_q[NUMW-1] ? $unsigned(-s3_num_q) : $unsigned(s3_num_q);
      s4_wsq_q  <= s3_wsq_q;
      s4_dz_q   <= (s3_den_q == '0);
      s4_tneg_q <= s3_num_q[NUMW-1] ^ s3_den_q[DENW-1];
    end
  end

  // --------------------------------------------------------------------------
  // s5: partial products of dot^2 and |w|^2 * limit^2
  // --------------------------------------------------------------------------
  logic [GW-1:0]      s5_geo_q;
  logic [DMW-1:0]     s5_dm_q;
  logic [NUMW-1:0]    s5_nm_q;
  logic               s5_dz_q, s5_tneg_q;
  logic [2*DH-1:0]    s5_ph_q;
  logic [DH+DL-1:0]   s5_pm_q;
  logic [2*DL-1:0]    s5_pl_q;
  logic [WH+M2W-1:0]  s5_lh_q;
  logic [WL+M2W-1:0]  s5_ll_q;
  logic [DH-1:0]      s4_dh;
  logic [DL-1:0]      s4_dl;

  assign s4_dh = s4_dotm_q[DENW-1:DL];
  assign s4_dl = s4_dotm_q[DL-1:0];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s5_geo_q  <= s4_geo_q;
      s5_dm_q   <= s4_dm_q;
      s5_nm_q   <= s4_nm_q;
      s5_dz_q   <= s4_dz_q;
      s5_tneg_q <= s4_tneg_q;
      s5_ph_q   <= (2*DH)'(s4_dh) * (2*DH)'(s4_dh);
      s5_pm_q   <= (DH+DL)'(s4_dh) * (DH+DL)'(s4_dl);
      s5_pl_q   <= (2*DL)'(s4_dl) * (2*DL)'(s4_dl);
      s5_lh_q   <= (WH+M2W)'(s4_wsq_q[SQW-1:WL]) * (WH+M2W)'(mca_sq_q);
      s5_ll_q   <= (WL+M2W)'(s4_wsq_q[WL-1:0]) * (WL+M2W)'(mca_sq_q);
    end
  end

  // --------------------------------------------------------------------------
  // s6: sum of partial products
  // --------------------------------------------------------------------------
  logic [GW-1:0]   s6_geo_q;
  logic [DMW-1:0]  s6_dm_q;
  logic [NUMW-1:0] s6_nm_q;
  logic            s6_dz_q, s6_tneg_q;
  logic [D2W-1:0]  s6_d2_q;
  logic [LW-1:0]   s6_lim_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s6_geo_q  <= s5_geo_q;
      s6_dm_q   <= s5_dm_q;
      s6_nm_q   <= s5_nm_q;
      s6_dz_q   <= s5_dz_q;
      s6_tneg_q <= s5_tneg_q;
      s6_d2_q   <= (D2W'(s5_ph_q) << (2*DL)) + (D2W'(s5_pm_q) << (DL + 1)) + D2W'(s5_pl_q);
      s6_lim_q  <= (LW'(s5_lh_q) << WL) + LW'(s5_ll_q);
    end
  end

  // --------------------------------------------------------------------------
  // s7: cosine reject, quotient overflow, divider setup
  // --------------------------------------------------------------------------
  logic [CMPW-1:0] cos_d2, cos_lim;
  logic [NW-1:0]   div_n;
  logic [NHW-1:0]  div_nh;
  logic            cos_rej, div_ovf;

  logic [GW-1:0]  dv_geo_q  [CW+1];
  logic           dv_miss_q [CW+1];
  logic           dv_tneg_q [CW+1];
  logic [DMW-1:0] dv_den_q  [CW+1];
  logic [DMW-1:0] dv_rem_q  [CW+1];
  logic [CW-1:0]  dv_nlo_q  [CW+1];
  logic [CW-1:0]  dv_quo_q  [CW+1];

  assign cos_d2  = CMPW'(s6_d2_q) << SH_D;
  assign cos_lim = CMPW'(s6_lim_q) << SH_L;
  assign cos_rej = cos_d2 > cos_lim;
  assign div_n   = {s6_nm_q, FB'(0)};
  assign div_nh  = div_n[NW-1:CW];
  assign div_ovf = OVW'(div_nh) >= OVW'(s6_dm_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dv_geo_q[0]  <= s6_geo_q;
      dv_miss_q[0] <= s6_dz_q | cos_rej | div_ovf;
      dv_tneg_q[0] <= s6_tneg_q;
      dv_den_q[0]  <= s6_dm_q;
      dv_rem_q[0]  <= DMW'(div_nh);
      dv_nlo_q[0]  <= div_n[CW-1:0];
      dv_quo_q[0]  <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < CW; k++) begin : g_div
    logic [DMW:0] rem_sh, rem_sub;
    logic         ge;

    assign rem_sh  = {dv_rem_q[k], dv_nlo_q[k][CW-1]};
    assign rem_sub = rem_sh - {1'b0, dv_den_q[k]};
    assign ge      = rem_sh >= {1'b0, dv_den_q[k]};

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        dv_geo_q[k+1]  <= dv_geo_q[k];
        dv_miss_q[k+1] <= dv_miss_q[k];
        dv_tneg_q[k+1] <= dv_tneg_q[k];
        dv_den_q[k+1]  <= dv_den_q[k];
        dv_rem_q[k+1]  <= ge ? rem_sub[DMW-1:0] : rem_sh[DMW-1:0];
        dv_nlo_q[k+1]  <= dv_nlo_q[k] << 1;
        dv_quo_q[k+1]  <= {dv_quo_q[k][CW-2:0], ge};
      end
    end
  end

  // --------------------------------------------------------------------------
  // q1: round to nearest
  // --------------------------------------------------------------------------
  logic [GW-1:0] q1_geo_q;
  logic          q1_miss_q, q1_tneg_q;
  logic [CW:0]   q1_qr_q;
  logic          rnd_up;

  assign rnd_up = {dv_rem_q[CW], 1'b0} >= {1'b0, dv_den_q[CW]};

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q1_geo_q  <= dv_geo_q[CW];
      q1_miss_q <= dv_miss_q[CW];
      q1_tneg_q <= dv_tneg_q[CW];
      q1_qr_q   <= {1'b0, dv_quo_q[CW]} + (CW+1)'(rnd_up);
    end
  end

  // --------------------------------------------------------------------------
  // q2: range check and sign of t
  // --------------------------------------------------------------------------
  logic [GW-1:0]        q2_geo_q;
  logic                 q2_miss_q;
  logic signed [CW-1:0] q2_t_q;
  logic                 t_big;

  assign t_big = q1_tneg_q ? (q1_qr_q > Q_HALF) : (q1_qr_q > (Q_HALF - 1'b1));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q2_geo_q  <= q1_geo_q;
      q2_miss_q <= q1_miss_q | t_big;
      q2_t_q    <= q1_tneg_q ? $signed(-q1_qr_q[CW-1:0]) : $signed(q1_qr_q[CW-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // q3: window check, ray offset products
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] q2_tl, q2_th;
  logic signed [DW-1:0] q2_vx, q2_vy;
  logic [GW-1:0]        q3_geo_q;
  logic                 q3_miss_q;
  logic signed [CW-1:0] q3_t_q;
  logic signed [MW-1:0] q3_mx_q, q3_my_q;

  assign q2_tl = $signed(q2_geo_q[OFF_TL +: CW]);
  assign q2_th = $signed(q2_geo_q[OFF_TH +: CW]);
  assign q2_vx = $signed(q2_geo_q[OFF_VX +: DW]);
  assign q2_vy = $signed(q2_geo_q[OFF_VY +: DW]);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q3_geo_q  <= q2_geo_q;
      q3_miss_q <= q2_miss_q | (q2_t_q < q2_tl) | (q2_t_q > q2_th);
      q3_t_q    <= q2_t_q;
      q3_mx_q   <= MW'(q2_vx) * MW'(q2_t_q);
      q3_my_q   <= MW'(q2_vy) * MW'(q2_t_q);
    end
  end

  // --------------------------------------------------------------------------
  // q4: scale offset down, ties away from zero
  // --------------------------------------------------------------------------
  logic [MW-1:0]        magx, magy, rndx, rndy;
  logic [GW-1:0]        q4_geo_q;
  logic                 q4_miss_q, q4_sgx_q, q4_sgy_q;
  logic signed [CW-1:0] q4_t_q;
  logic [SW-1:0]        q4_sx_q, q4_sy_q;

  assign magx = q3_mx_q[MW-1] ? $unsigned(-q3_mx_q) : $unsigned(q3_mx_q);
  assign magy = q3_my_q[MW-1] ? $unsigned(-q3_my_q) : $unsigned(q3_my_q);
  assign rndx = magx + RND_HLF;
  assign rndy = magy + RND_HLF;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q4_geo_q  <= q3_geo_q;
      q4_miss_q <= q3_miss_q;
      q4_t_q    <= q3_t_q;
      q4_sgx_q  <= q3_mx_q[MW-1];
      q4_sgy_q  <= q3_my_q[MW-1];
      q4_sx_q   <= rndx[MW-1:FB];
      q4_sy_q   <= rndy[MW-1:FB];
    end
  end

  // --------------------------------------------------------------------------
  // q5: hit point
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] q4_ox, q4_oy;
  logic signed [HW-1:0] offx, offy;
  logic [GW-1:0]        q5_geo_q;
  logic                 q5_miss_q;
  logic signed [CW-1:0] q5_t_q;
  logic signed [HW-1:0] q5_hx_q, q5_hy_q;

  assign q4_ox = $signed(q4_geo_q[OFF_OX +: CW]);
  assign q4_oy = $signed(q4_geo_q[OFF_OY +: CW]);
  assign offx  = $signed(HW'(q4_sx_q));
  assign offy  = $signed(HW'(q4_sy_q));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q5_geo_q  <= q4_geo_q;
      q5_miss_q <= q4_miss_q;
      q5_t_q    <= q4_t_q;
      q5_hx_q   <= HW'(q4_ox) + (q4_sgx_q ? -offx : offx);
      q5_hy_q   <= HW'(q4_oy) + (q4_sgy_q ? -offy : offy);
    end
  end

  // --------------------------------------------------------------------------
  // q6: hit point relative to both endpoints
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] q5_ax, q5_ay, q5_bx, q5_by;
  logic                 q6_miss_q;
  logic signed [CW-1:0] q6_t_q;
  logic signed [EW-1:0] q6_eax_q, q6_eay_q, q6_ebx_q, q6_eby_q;

  assign q5_ax = $signed(q5_geo_q[OFF_AX +: CW]);
  assign q5_ay = $signed(q5_geo_q[OFF_AY +: CW]);
  assign q5_bx = $signed(q5_geo_q[OFF_BX +: CW]);
  assign q5_by = $signed(q5_geo_q[OFF_BY +: CW]);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q6_miss_q <= q5_miss_q;
      q6_t_q    <= q5_t_q;
      q6_eax_q  <= EW'(q5_hx_q) - EW'(q5_ax);
      q6_eay_q  <= EW'(q5_hy_q) - EW'(q5_ay);
      q6_ebx_q  <= EW'(q5_hx_q) - EW'(q5_bx);
      q6_eby_q  <= EW'(q5_hy_q) - EW'(q5_by);
    end
  end

  // --------------------------------------------------------------------------
  // q7: distance magnitudes, partial products of the between test
  // --------------------------------------------------------------------------
  logic                  q7_miss_q;
  logic signed [CW-1:0]  q7_t_q;
  logic [EW-1:0]         q7_uax_q, q7_uay_q, q7_ubx_q, q7_uby_q;
  logic signed [PHW-1:0] q7_pxh_q, q7_pyh_q;
  logic signed [PLW-1:0] q7_pxl_q, q7_pyl_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q7_miss_q <= q6_miss_q;
      q7_t_q    <= q6_t_q;
      q7_uax_q  <= q6_eax_q[EW-1] ? $unsigned(-q6_eax_q) : $unsigned(q6_eax_q);
      q7_uay_q  <= q6_eay_q[EW-1] ? $unsigned(-q6_eay_q) : $unsigned(q6_eay_q);
      q7_ubx_q  <= q6_ebx_q[EW-1] ? $unsigned(-q6_ebx_q) : $unsigned(q6_ebx_q);
      q7_uby_q  <= q6_eby_q[EW-1] ? $unsigned(-q6_eby_q) : $unsigned(q6_eby_q);
      q7_pxh_q  <= PHW'(q6_eax_q) * PHW'($signed(q6_ebx_q[EW-1:BL]));
      q7_pyh_q  <= PHW'(q6_eay_q) * PHW'($signed(q6_eby_q[EW-1:BL]));
      q7_pxl_q  <= PLW'(q6_eax_q) * $signed(PLW'(q6_ebx_q[BL-1:0]));
      q7_pyl_q  <= PLW'(q6_eay_q) * $signed(PLW'(q6_eby_q[BL-1:0]));
    end
  end

  // --------------------------------------------------------------------------
  // q8: tolerance box, squared distances, between sign
  // --------------------------------------------------------------------------
  logic signed [BTW-1:0] btw;
  logic                  q8_miss_q, q8_btw_neg_q;
  logic signed [CW-1:0]  q8_t_q;
  logic [3:0]            q8_lt_q;
  logic [TSW-1:0]        q8_sax_q, q8_say_q, q8_sbx_q, q8_sby_q;

  assign btw = (BTW'(q7_pxh_q) <<< BL) + BTW'(q7_pxl_q)
             + (BTW'(q7_pyh_q) <<< BL) + BTW'(q7_pyl_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q8_miss_q    <= q7_miss_q;
      q8_t_q       <= q7_t_q;
      q8_btw_neg_q <= btw[BTW-1];
      q8_lt_q      <= {q7_uby_q < EW'(tol_q), q7_ubx_q < EW'(tol_q),
                       q7_uay_q < EW'(tol_q), q7_uax_q < EW'(tol_q)};
      q8_sax_q     <= TSW'(q7_uax_q[TOL_WIDTH-1:0]) * TSW'(q7_uax_q[TOL_WIDTH-1:0]);
      q8_say_q     <= TSW'(q7_uay_q[TOL_WIDTH-1:0]) * TSW'(q7_uay_q[TOL_WIDTH-1:0]);
      q8_sbx_q     <= TSW'(q7_ubx_q[TOL_WIDTH-1:0]) * TSW'(q7_ubx_q[TOL_WIDTH-1:0]);
      q8_sby_q     <= TSW'(q7_uby_q[TOL_WIDTH-1:0]) * TSW'(q7_uby_q[TOL_WIDTH-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // q9: endpoint test and final decision
  // --------------------------------------------------------------------------
  logic          near_a, near_b, fin_hit;
  logic          q9_hit_q;
  logic [CW-1:0] q9_t_q;

  assign near_a  = q8_lt_q[0] & q8_lt_q[1] &
                   (((TSW+1)'(q8_sax_q) + (TSW+1)'(q8_say_q)) < (TSW+1)'(tol_sq_q));
  assign near_b  = q8_lt_q[2] & q8_lt_q[3] &
                   (((TSW+1)'(q8_sbx_q) + (TSW+1)'(q8_sby_q)) < (TSW+1)'(tol_sq_q));
  assign fin_hit = ~q8_miss_q & (near_a | near_b | q8_btw_neg_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q9_hit_q <= fin_hit;
      q9_t_q   <= fin_hit ? $unsigned(q8_t_q) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // output register and skid register
  // --------------------------------------------------------------------------
  logic          out_load, skid_load;
  logic          out_hit_q, skid_hit_q;
  logic [CW-1:0] out_t_q, skid_t_q;

  assign out_load  = ~out_vld_q | m_axis_tready;
  assign skid_load = ~out_load & vld_q[NST-1] & pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q  <= skid_vld_q | vld_q[NST-1];
      skid_vld_q <= 1'b0;
    end else if (skid_load) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q <= skid_vld_q ? skid_hit_q : q9_hit_q;
      out_t_q   <= skid_vld_q ? skid_t_q : q9_t_q;
    end
    if (skid_load) begin
      skid_hit_q <= q9_hit_q;
      skid_t_q   <= q9_t_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = OTW_'(out_t_q);

endmodule

@@ design/rsi_checker.sv @@
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks on the intersection pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_checker
  import rsi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int unsigned OTW_ = ((COORD_WIDTH + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OTW_-1:0] m_axis_tdata,
  input logic            m_axis_tuser
);

  // an empty output stage never holds off the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a miss carries a zero parameter
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with nonzero hit_t");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind ray_segment_intersection rsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rsi_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray against segment intersection pipeline.
// Items go in over the input stream and every result is compared with an
// integer predictor of the crossing test. Directed corner items come first,
// then random geometry under several register settings, with random idling
// on both stream sides, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import rsi_pkg::*;

  localparam int unsigned ITW = 296;
  localparam int unsigned OTW = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_LAT = 49;

  typedef struct {
    int ox, oy, vx, vy, tl, th, ax, ay, bx, by;
  } ray_item_t;

  typedef struct {
    logic        hit;
    logic [31:0] t;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ITW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OTW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // register mirror
  longint max_cos_cfg = 58982;
  longint tol_cfg = 1;

  crossing_t expected_q[$];
  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_hits = 0;
  int cycle_cnt = 0;
  bit quiet = 1'b0;
  int rx_hold_left = 0;
  int rx_stall_left = 0;

  ray_segment_intersection u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready,
    .s_axis_tdata,                  // ox, oy, vx, vy, t_low, t_high, ax, ay, bx, by
    .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata,                  // hit_t
    .m_axis_tuser,                  // hit
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, expected_q.size());
      $display("** ray_segment_intersection: FAILED **");
      $finish;
    end
  end

  function automatic longint round_q16(longint x);
    longint m;
    m = ((x < 0) ? -x : x) + 32768;
    m = m >>> 16;
    return (x < 0) ? -m : m;
  endfunction

  function automatic bit near_end(longint ex, longint ey, longint tol);
    longint ux, uy;
    ux = (ex < 0) ? -ex : ex;
    uy = (ey < 0) ? -ey : ey;
    if (ux >= tol || uy >= tol) return 1'b0;
    return (ux * ux + uy * uy) < tol * tol;
  endfunction

  // exact integer crossing test at the current register settings
  function automatic crossing_t predict_crossing(ray_item_t it);
    logic signed [127:0] vx, vy, wx, wy, px, py, den, dotv, d2, wsq, lsq;
    logic signed [127:0] num, an, ad, q, r, mca, between;
    crossing_t res;
    bit neg;
    longint t, hx, hy;
    res.hit = 1'b0;
    res.t = '0;
    vx = longint'(it.vx);
    vy = longint'(it.vy);
    wx = longint'(it.bx) - longint'(it.ax);
    wy = longint'(it.by) - longint'(it.ay);
    px = longint'(it.ox) - longint'(it.ax);
    py = longint'(it.oy) - longint'(it.ay);
    den = vx * wy - vy * wx;
    if (den == 0) return res;
    // cosine limit on squares
    dotv = vx * wx + vy * wy;
    if (dotv < 0) dotv = -dotv;
    d2 = dotv * dotv;
    wsq = wx * wx + wy * wy;
    mca = max_cos_cfg;
    lsq = wsq * (mca * mca);
    if (d2 > lsq) return res;
    // t with round to nearest, ties away from zero
    num = wx * py - wy * px;
    neg = (num < 0) != (den < 0);
    an = ((num < 0) ? -num : num) <<< 16;
    ad = (den < 0) ? -den : den;
    q = an / ad;
    r = an % ad;
    if (2 * r >= ad) q = q + 1;
    if (q > (neg ? 128'sd2147483648 : 128'sd2147483647)) return res;
    t = neg ? -longint'(q) : longint'(q);
    if (t < it.tl || t > it.th) return res;
    hx = it.ox + round_q16(it.vx * t);
    hy = it.oy + round_q16(it.vy * t);
    if (!near_end(hx - it.ax, hy - it.ay, tol_cfg) &&
        !near_end(hx - it.bx, hy - it.by, tol_cfg)) begin
      between = (128'(hx) - it.ax) * (128'(hx) - it.bx) +
                (128'(hy) - it.ay) * (128'(hy) - it.by);
      if (between >= 0) return res;
    end
    res.hit = 1'b1;
    res.t = t[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s at result %0d: got %0d, expected %0d", what, n_results, got, want);
    n_errors++;
  endtask

  // output side: check each transaction, then decide on ready
  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tuser, 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tuser !== want.hit) report_mismatch("hit", m_axis_tuser, want.hit);
        if (m_axis_tdata !== want.t)
          report_mismatch("hit_t", $signed(m_axis_tdata), $signed(want.t));
      end
      n_results++;
    end
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 12);
    end
  end

  // offer one item and wait for its transaction
  task automatic send_ray(ray_item_t it);
    crossing_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, it.by, it.bx, it.ay, it.ax, it.th, it.tl,
                     it.vy[17:0], it.vx[17:0], it.oy, it.ox};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_crossing(it);
    expected_q.insert(expected_q.size(), pred);
    if (pred.hit) n_hits++;
    n_items++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(rsi_reg_e idx, longint value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MAX_COS) max_cos_cfg = value;
    else tol_cfg = value;
    @(posedge clk_i);
  endtask

  function automatic ray_item_t mk_ray(int ox, int oy, int vx, int vy, int tl, int th,
                                      int ax, int ay, int bx, int by);
    ray_item_t it;
    it.ox = ox; it.oy = oy; it.vx = vx; it.vy = vy; it.tl = tl; it.th = th;
    it.ax = ax; it.ay = ay; it.bx = bx; it.by = by;
    return it;
  endfunction

  function automatic int rand_coord();
    return int'($urandom);
  endfunction

  // signed random offset in [-center, hi - center]
  function automatic int rand_off(int hi, int center);
    return int'($urandom_range(0, hi)) - center;
  endfunction

  // well-formed crossing: point on (or near) the segment, ray aimed through it
  function automatic ray_item_t make_crossing(real span);
    ray_item_t it;
    real ax, ay, bx, by, s, ang, vx, vy, t, px, py;
    ax = rand_off(20000, 10000) * span / 10000.0;
    ay = rand_off(20000, 10000) * span / 10000.0;
    bx = rand_off(20000, 10000) * span / 10000.0;
    by = rand_off(20000, 10000) * span / 10000.0;
    case ($urandom_range(0, 5))
      0: s = 0.0;
      1: s = 1.0;
      2: s = rand_off(1000, 500) / 2000.0 + ($urandom_range(0, 1) ? 1.0 : 0.0);
      default: s = $urandom_range(1, 999) / 1000.0;
    endcase
    px = ax + s * (bx - ax);
    py = ay + s * (by - ay);
    ang = $urandom_range(0, 35999) * 6.283185307 / 36000.0;
    vx = $cos(ang);
    vy = $sin(ang);
    t = rand_off(20000, 4000) * span / 10000.0;
    it.ax = $rtoi(ax * 65536.0); it.ay = $rtoi(ay * 65536.0);
    it.bx = $rtoi(bx * 65536.0); it.by = $rtoi(by * 65536.0);
    it.vx = $rtoi(vx * 65536.0); it.vy = $rtoi(vy * 65536.0);
    it.ox = $rtoi((px - vx * t) * 65536.0);
    it.oy = $rtoi((py - vy * t) * 65536.0);
    it.tl = $rtoi((t - $urandom_range(0, 3000) / 1000.0) * 65536.0);
    it.th = $rtoi((t + $urandom_range(0, 3000) / 1000.0) * 65536.0);
    if ($urandom_range(0, 9) == 0) it.tl = it.th + 1;
    return it;
  endfunction

  function automatic ray_item_t make_noise();
    ray_item_t it;
    it = mk_ray(rand_coord(), rand_coord(), $urandom_range(0, 131072) - 65536,
                $urandom_range(0, 131072) - 65536, rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_coord());
    if ($urandom_range(0, 1)) begin
      it.tl = -2147483647 - 1;
      it.th = 2147483647;
    end
    return it;
  endfunction

  task automatic test_directed();
    int one;
    one = 65536;
    // plain crossing, segment on x = 5, ray along +x
    send_ray(mk_ray(0, 0, one, 0, 0, 100 * one, 5 * one, -one, 5 * one, one));
    // negative t behind origin, window allows it
    send_ray(mk_ray(0, 0, -one, 0, -100 * one, 100 * one, 5 * one, -one, 5 * one, one));
    // parallel ray
    send_ray(mk_ray(0, 0, 0, one, -100 * one, 100 * one, 5 * one, -one, 5 * one, one));
    // degenerate segment, a equals b
    send_ray(mk_ray(0, 0, one, 0, -100 * one, 100 * one, 5 * one, 0, 5 * one, 0));
    // zero direction
    send_ray(mk_ray(0, 0, 0, 0, -100 * one, 100 * one, 5 * one, -one, 5 * one, one));
    // shallow angle, rejected by the cosine limit
    send_ray(mk_ray(0, 0, one, 0, -100 * one, 100 * one, 0, one, 10 * one, 2 * one));
    // window inverted
    send_ray(mk_ray(0, 0, one, 0, 10 * one, 0, 5 * one, -one, 5 * one, one));
    // t exactly on both window edges, then t just below the low edge
    send_ray(mk_ray(0, 0, one, 0, 5 * one, 5 * one, 5 * one, -one, 5 * one, one));
    send_ray(mk_ray(0, 0, one, 0, 5 * one + 1, 9 * one, 5 * one, -one, 5 * one, one));
    // hit through an endpoint, and just beyond it
    send_ray(mk_ray(0, one, one, 0, 0, 100 * one, 5 * one, -one, 5 * one, one));
    send_ray(mk_ray(0, one + 1, one, 0, 0, 100 * one, 5 * one, -one, 5 * one, one));
    // division overflow, far segment reached at a near-perpendicular angle
    send_ray(mk_ray(-2147483647 - 1, 0, one, 1, -2147483647 - 1, 2147483647,
                    2147483647, -2147483647 - 1, 2147483647, 2147483647));
    send_ray(mk_ray(0, 0, 1, one, -2147483647 - 1, 2147483647,
                    -2147483647 - 1, 2147483647, 2147483647, 2147483647));
    // direction components at the extremes, not unit length
    send_ray(mk_ray(0, 0, one, one, 0, 100 * one, 5 * one, -9 * one, 5 * one, 9 * one));
    send_ray(mk_ray(0, 0, -one, -one, -100 * one, 0, 5 * one, -9 * one, 5 * one, 9 * one));
    send_ray(mk_ray(3 * one, 0, -131072, 1, -100 * one, 100 * one, 0, -one, 0, one));
    // coordinate extremes
    send_ray(mk_ray(2147483647, -2147483647 - 1, -one, one, -2147483647 - 1, 2147483647,
                    -2147483647 - 1, -2147483647 - 1, 2147483647, 2147483647));
    send_ray(mk_ray(-1, -1, one, -one, -2147483647 - 1, 2147483647,
                    2147483647, -2147483647 - 1, -2147483647 - 1, 2147483647));
    send_ray(mk_ray(0, 0, 46341, 46341, 0, 2147483647, 20 * one, 0, 0, 20 * one));
    end_burst();
    drain();
  endtask

  task automatic test_random_phase(int count, int noise_pct, real span);
    repeat (count) begin
      if ($urandom_range(1, 100) <= noise_pct) send_ray(make_noise());
      else send_ray(make_crossing(span));
    end
    end_burst();
    drain();
  endtask

  task automatic test_register_settings();
    // tolerance off, cosine limit wide open
    write_reg(REG_MAX_COS, 65536);
    write_reg(REG_END_TOL, 0);
    test_random_phase(80, 20, 500.0);
    // widest tolerance, cosine limit shut
    write_reg(REG_MAX_COS, 0);
    write_reg(REG_END_TOL, 65535);
    test_random_phase(50, 15, 2.0);
    // random settings
    write_reg(REG_MAX_COS, $urandom_range(0, 65536));
    write_reg(REG_END_TOL, $urandom_range(0, 65535));
    test_random_phase(80, 20, 50.0);
    write_reg(REG_MAX_COS, 58982);
    write_reg(REG_END_TOL, $urandom_range(1, 300));
    test_random_phase(80, 20, 1000.0);
  endtask

  task automatic test_output_stall();
    rx_hold_left = 300;
    repeat (90) send_ray(make_crossing(100.0));
    end_burst();
    drain();
  endtask

  task automatic test_drain_pause();
    repeat (20) send_ray(make_crossing(10.0));
    end_burst();
    drain();
    repeat (20) send_ray(make_noise());
    end_burst();
    drain();
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (50) send_ray(make_crossing(200.0));
    end_burst();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random_phase(60, 20, 100.0);
    test_register_settings();
    test_output_stall();
    test_drain_pause();
    test_back_to_back();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    $display("covered %0d items and %0d results (%0d hits) over several register settings,",
             n_items, n_results, n_hits);
    $display("with random idling, a long output stall and a drain pause");
    if (n_errors == 0) begin
      $display("** ray_segment_intersection: PASSED **");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("** ray_segment_intersection: FAILED **");
    end
    $finish;
  end

endmodule

@@ ray_segment_intersection.f @@
design/rsi_pkg.sv
design/ray_segment_intersection.sv
design/rsi_checker.sv
tb/tb_top.sv
